// ----- hw/rtl/ipid_pkg.sv -----
// ----------------------------------------------------------------------------
// ipid_pkg
// shared types, command and register codes, and helpers for the incremental
// pid speed/position core
// ----------------------------------------------------------------------------
package ipid_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_POSITION_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UPDATE_DIVIDE = 3'd4;

  // command codes
  localparam logic [1:0] CMD_TICK       = 2'd0;
  localparam logic [1:0] CMD_SET_TARGET = 2'd1;
  localparam logic [1:0] CMD_CLEAR      = 2'd2;

  // register reset values
  localparam logic [15:0] GAIN_P_RESET = 16'd1280;
  localparam logic [15:0] GAIN_I_RESET = 16'd512;
  localparam logic [15:0] GAIN_D_RESET = 16'd768;
  localparam logic [7:0]  DIVIDE_RESET = 8'd10;

  // drive limit, +/-100 percent in q8
  localparam logic signed [15:0] DRIVE_LIMIT = 16'sd25600;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] speed_one;
    logic signed [15:0] speed_two;
    logic signed [31:0] target_value;
  } in_item_t;

  typedef struct packed {
    logic               motor_select;
    logic signed [15:0] drive_q8;
    logic signed [7:0]  pwm_command;
    logic signed [31:0] actual_value;
    logic signed [31:0] error_value;
  } result_t;

  // one control update handed from the state stage to the drive pipe
  typedef struct packed {
    logic               clear;
    logic               mode;
    logic signed [31:0] actual;
    logic signed [31:0] e0;
    logic signed [31:0] e1;
    logic signed [31:0] e2;
  } update_t;

  // saturate a 33-bit sum to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] == v[31]) r = v[31:0];
    else if (v[32]) r = 32'sh8000_0000;
    else r = 32'sh7fff_ffff;
    return r;
  endfunction

endpackage

// ----- hw/rtl/ipid_stream_if.sv -----
// ----------------------------------------------------------------------------
// ipid_stream_if
// valid/ready channel carrying one word of a given payload type
// ----------------------------------------------------------------------------
interface ipid_stream_if #(
  parameter type item_t = logic
);

  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// ----- hw/rtl/ipid_drive_pipe.sv -----
// ----------------------------------------------------------------------------
// ipid_drive_pipe
// gain multiplies, drive accumulation with clamp, and the result register
// ----------------------------------------------------------------------------
module ipid_drive_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              upd_valid,
  input  ipid_pkg::update_t upd,
  output logic              upd_ready,
  input  logic [15:0]       gain_p,
  input  logic [15:0]       gain_i,
  input  logic [15:0]       gain_d,
  ipid_stream_if.source     result
);
  import ipid_pkg::*;

  logic               m_valid;
  logic               m_clear;
  logic               m_mode;
  logic signed [31:0] m_actual;
  logic signed [31:0] m_err;
  logic signed [49:0] prod_p;
  logic signed [48:0] prod_i;
  logic signed [50:0] prod_d;
  logic signed [15:0] drive_acc;

  logic               out_free;
  logic               m_ready;
  logic signed [16:0] gp_s;
  logic signed [16:0] gi_s;
  logic signed [16:0] gd_s;
  logic signed [32:0] diff_p;
  logic signed [33:0] diff_d;
  logic signed [53:0] drive_sum;
  logic signed [15:0] drive_next;
  logic signed [15:0] pwm_wide;

  assign out_free  = !result.valid || result.ready;
  assign m_ready   = !m_valid || out_free;
  assign upd_ready = m_ready;

  assign gp_s = {1'b0, gain_p};
  assign gi_s = {1'b0, gain_i};
  assign gd_s = {1'b0, gain_d};

  // first and second differences of the error history
  assign diff_p = 33'(upd.e0) - 33'(upd.e1);
  assign diff_d = 34'(upd.e0) - (34'(upd.e1) <<< 1) + 34'(upd.e2);

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_ready) begin
      m_valid <= upd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && upd_valid) begin
      m_clear  <= upd.clear;
      m_mode   <= upd.mode;
      m_actual <= upd.actual;
      m_err    <= upd.e0;
      prod_p   <= diff_p * gp_s;
      prod_i   <= upd.e0 * gi_s;
      prod_d   <= diff_d * gd_s;
    end
  end

  // accumulate and clamp
  assign drive_sum = 54'(drive_acc) + 54'(prod_p) + 54'(prod_i) + 54'(prod_d);

  always_comb begin
    priority if (drive_sum > 54'(DRIVE_LIMIT)) drive_next = DRIVE_LIMIT;
    else if (drive_sum < -54'(DRIVE_LIMIT)) drive_next = -DRIVE_LIMIT;
    else drive_next = drive_sum[15:0];
  end

  // divide by 256 rounding toward zero
  assign pwm_wide = drive_next[15] ? ((drive_next + 16'sd255) >>> 8) : (drive_next >>> 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      drive_acc    <= '0;
    end else if (m_valid && out_free) begin
      result.valid <= !m_clear;
      drive_acc    <= m_clear ? 16'sd0 : drive_next;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_valid && out_free && !m_clear) begin
      result.payload.motor_select <= m_mode;
      result.payload.drive_q8     <= drive_next;
      result.payload.pwm_command  <= pwm_wide[7:0];
      result.payload.actual_value <= m_actual;
      result.payload.error_value  <= m_err;
    end
  end

endmodule

// ----- hw/rtl/incremental_pid_speed_position_core.sv -----
// ----------------------------------------------------------------------------
// incremental_pid_speed_position_core
// incremental pid controller for a two-motor rig, speed or position-follow mode
// ----------------------------------------------------------------------------
// One word is accepted per clock while the state stage is empty or draining.
// Ticks, set-target and clear words update the loop state in the cycle they are
// accepted; a tick that completes a control update yields a result word through
// the state stage, multiply stage, and drive accumulate and clamp stage. The
// rate is set by the state stage, where the accumulate and error subtract close
// within that stage, and by the drive accumulator, which closes in the last stage.
// A stalled result holds the pipe only once all three stages are full.
module incremental_pid_speed_position_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ipid_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ipid_pkg::CFG_DATA_W-1:0]  cfg_data,
  ipid_stream_if.sink                      in_item,
  ipid_stream_if.source                    result
);
  import ipid_pkg::*;

  // configuration registers
  logic        position_mode;
  logic [15:0] gain_p;
  logic [15:0] gain_i;
  logic [15:0] gain_d;
  logic [7:0]  update_divide;

  // loop state
  logic [7:0]         tick_counter;
  logic signed [31:0] target_acc;
  logic signed [31:0] actual_acc;
  logic signed [31:0] err_now;
  logic signed [31:0] err_prev;
  logic signed [31:0] err_prev2;

  // state stage register
  logic    upd_valid;
  update_t upd;
  logic    pipe_ready;

  logic               in_ready;
  logic               accept;
  logic [1:0]         cmd;
  logic [7:0]         tick_next;
  logic               do_update;
  logic               produces;
  logic signed [31:0] speed_one_ext;
  logic signed [31:0] target_pos;
  logic signed [31:0] actual_pos;
  logic signed [31:0] target_use;
  logic signed [31:0] actual_use;
  logic signed [31:0] err_calc;

  // config writes, indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      position_mode <= 1'b0;
      gain_p        <= GAIN_P_RESET;
      gain_i        <= GAIN_I_RESET;
      gain_d        <= GAIN_D_RESET;
      update_divide <= DIVIDE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POSITION_MODE: position_mode <= cfg_data[0];
        REG_GAIN_P:        gain_p        <= cfg_data;
        REG_GAIN_I:        gain_i        <= cfg_data;
        REG_GAIN_D:        gain_d        <= cfg_data;
        REG_UPDATE_DIVIDE: update_divide <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input side handshake: the stage takes a word when empty or draining
  assign in_ready      = !upd_valid || pipe_ready;
  assign in_item.ready = in_ready;
  assign accept        = in_item.valid && in_ready;
  assign cmd           = in_item.payload.cmd;

  // tick divider, compared with >= so a lowered divider fires at once
  assign tick_next = tick_counter + 8'd1;
  assign do_update = (tick_next >= update_divide);

  // only control updates and clears travel down the pipe
  assign produces = ((cmd == CMD_TICK) && do_update) || (cmd == CMD_CLEAR);

  // measured value and target for this update
  assign speed_one_ext = 32'(in_item.payload.speed_one);
  assign target_pos    = sat32(33'(target_acc) + 33'(in_item.payload.speed_one));
  assign actual_pos    = sat32(33'(actual_acc) + 33'(in_item.payload.speed_two));
  assign target_use    = position_mode ? target_pos : target_acc;
  assign actual_use    = position_mode ? actual_pos : speed_one_ext;
  assign err_calc      = sat32(33'(target_use) - 33'(actual_use));

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      target_acc   <= '0;
      actual_acc   <= '0;
      err_now      <= '0;
      err_prev     <= '0;
      err_prev2    <= '0;
      upd_valid    <= 1'b0;
    end else begin
      if (accept) begin
        upd_valid <= produces;
      end else if (pipe_ready) begin
        upd_valid <= 1'b0;
      end
      if (accept) begin
        unique case (cmd)
          CMD_TICK: begin
            tick_counter <= do_update ? 8'd0 : tick_next;
            if (do_update) begin
              target_acc <= target_use;
              actual_acc <= actual_use;
              err_prev2  <= err_prev;
              err_prev   <= err_now;
              err_now    <= err_calc;
            end
          end
          CMD_SET_TARGET: begin
            target_acc <= in_item.payload.target_value;
          end
          CMD_CLEAR: begin
            // tick counter and registers survive a clear
            target_acc <= '0;
            actual_acc <= '0;
            err_now    <= '0;
            err_prev   <= '0;
            err_prev2  <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // update word: the error history after the shift
  always_ff @(posedge clk) begin
    if (accept && produces) begin
      upd.clear  <= (cmd == CMD_CLEAR);
      upd.mode   <= position_mode;
      upd.actual <= actual_use;
      upd.e0     <= err_calc;
      upd.e1     <= err_now;
      upd.e2     <= err_prev;
    end
  end

  // multiply and drive accumulate stages
  ipid_drive_pipe u_drive (
    .clk       (clk),
    .rst       (rst),
    .upd_valid (upd_valid),
    .upd       (upd),
    .upd_ready (pipe_ready),
    .gain_p    (gain_p),
    .gain_i    (gain_i),
    .gain_d    (gain_d),
    .result    (result)
  );

  // a clear leaves an empty error history behind
  a_clear_empties_history: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_CLEAR) |=> (err_now == 0) && (err_prev == 0) && (err_prev2 == 0))
    else $error("error history not cleared");

  // the drive never leaves the clamp window
  a_drive_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.payload.drive_q8 <= DRIVE_LIMIT) &&
                     (result.payload.drive_q8 >= -DRIVE_LIMIT))
    else $error("drive outside clamp window");

  // pwm sign follows whole-percent drive
  a_pwm_sign: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.payload.pwm_command[7] == (result.payload.drive_q8 <= -16'sd256)))
    else $error("pwm sign mismatch");

  // a word held in the state stage stays put while the pipe cannot take it
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    upd_valid && !pipe_ready |=> upd_valid && $stable(upd))
    else $error("state stage overwritten while stalled");

endmodule

// ----- verif/incremental_pid_speed_position_core_tb.sv -----
// ----------------------------------------------------------------------------
// incremental_pid_speed_position_core_tb
// self-checking bench for the incremental pid core: words carrying ticks,
// target loads and clears go in on a valid/ready channel, while a behavioral
// controller kept in the bench predicts every drive update that should come
// back. Both channel ends idle at random, and the registers are reprogrammed
// between phases while the core is quiet.
// ----------------------------------------------------------------------------
module incremental_pid_speed_position_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ipid_pkg::*;

  // the one command code the package leaves unnamed; the core must ignore it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // three pipe stages, plus some margin before touching the registers
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int MAX_WAIT      = 13;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ipid_stream_if #(.item_t(in_item_t)) in_ch ();
  ipid_stream_if #(.item_t(result_t))  res_ch ();

  incremental_pid_speed_position_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_ch),
    .result    (res_ch)
  );

  // words waiting for the driver, and drive updates waiting for the core
  in_item_t queued_words[$];
  result_t  expected_updates[$];

  // register shadows as the core should hold them
  logic        sh_mode;
  logic [15:0] sh_gain_p;
  logic [15:0] sh_gain_i;
  logic [15:0] sh_gain_d;
  logic [7:0]  sh_divide;

  // controller state of the bench's own copy of the loop
  logic [7:0]         tick_count;
  logic signed [31:0] target_acc;
  logic signed [31:0] actual_acc;
  logic signed [31:0] err_now;
  logic signed [31:0] err_prev;
  logic signed [31:0] err_prev2;
  logic signed [15:0] drive_acc;

  bit in_fired;
  bit res_fired;
  bit calm;
  int send_gap;
  int stall_left;
  int failures;
  int cycle_count;

  // --------------------------------------------------------------------------
  // clock, run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------

  // idle draw for either side; calm phases run back to back
  function automatic int draw_wait();
    if (calm) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // one accepted word through the controller; a finished update is queued
  function automatic void advance_controller(in_item_t w);
    longint  e0;
    longint  e1;
    longint  e2;
    longint  delta;
    longint  drive;
    int      pct;
    result_t r;
    case (w.cmd)
      CMD_SET_TARGET: target_acc = w.target_value;
      CMD_CLEAR: begin
        // tick divider and registers survive a clear
        target_acc = '0;
        actual_acc = '0;
        err_now    = '0;
        err_prev   = '0;
        err_prev2  = '0;
        drive_acc  = '0;
      end
      CMD_TICK: begin
        tick_count = tick_count + 8'd1;
        // >= so a lowered divider fires on the next tick, and zero fires always
        if (tick_count >= sh_divide) begin
          tick_count = '0;
          if (!sh_mode) begin
            actual_acc = 32'(w.speed_one);
          end else begin
            // position follow: both sides integrate their encoder
            target_acc = clip32(longint'(target_acc) + longint'(w.speed_one));
            actual_acc = clip32(longint'(actual_acc) + longint'(w.speed_two));
          end
          err_prev2 = err_prev;
          err_prev  = err_now;
          err_now   = clip32(longint'(target_acc) - longint'(actual_acc));
          e0 = longint'(err_now);
          e1 = longint'(err_prev);
          e2 = longint'(err_prev2);
          // q8.8 gains times integer errors give a q8 step, summed exactly
          delta = longint'(sh_gain_p) * (e0 - e1)
                + longint'(sh_gain_i) * e0
                + longint'(sh_gain_d) * (e0 - 2 * e1 + e2);
          drive = longint'(drive_acc) + delta;
          if (drive > longint'(DRIVE_LIMIT)) drive = longint'(DRIVE_LIMIT);
          if (drive < -longint'(DRIVE_LIMIT)) drive = -longint'(DRIVE_LIMIT);
          drive_acc = drive[15:0];
          // whole percent, truncated toward zero
          pct = int'(drive_acc) / 256;
          r.motor_select = sh_mode;
          r.drive_q8     = drive_acc;
          r.pwm_command  = pct[7:0];
          r.actual_value = actual_acc;
          r.error_value  = err_now;
          expected_updates.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  function automatic void check_update(result_t got);
    result_t want;
    if (expected_updates.size() == 0) begin
      $error("drive word with no update pending: drive_q8 %0d", got.drive_q8);
      failures++;
    end else begin
      want = expected_updates.pop_front();
      check_field("motor_select", longint'(want.motor_select),
                  longint'(got.motor_select));
      check_field("drive_q8", longint'(want.drive_q8), longint'(got.drive_q8));
      check_field("pwm_command", longint'(want.pwm_command),
                  longint'(got.pwm_command));
      check_field("actual_value", longint'(want.actual_value),
                  longint'(got.actual_value));
      check_field("error_value", longint'(want.error_value),
                  longint'(got.error_value));
    end
  endfunction

  function automatic void queue_word(logic [1:0] cmd, logic signed [15:0] s1,
                                     logic signed [15:0] s2, logic signed [31:0] tgt);
    in_item_t w;
    w.cmd          = cmd;
    w.speed_one    = s1;
    w.speed_two    = s2;
    w.target_value = tgt;
    queued_words.push_back(w);
  endfunction

  function automatic logic signed [15:0] pick_speed();
    logic signed [15:0] s;
    case ($urandom_range(0, 3))
      0: s = 16'($urandom());
      1: s = 16'(int'($urandom_range(0, 80)) - 40);
      2: begin
        case ($urandom_range(0, 3))
          0: s = 16'sh7fff;
          1: s = 16'sh8000;
          2: s = 16'sh0000;
          default: s = 16'shffff;
        endcase
      end
      default: s = 16'(int'($urandom_range(0, 600)) - 300);
    endcase
    return s;
  endfunction

  function automatic logic signed [31:0] pick_target();
    logic signed [31:0] t;
    case ($urandom_range(0, 2))
      0: t = $urandom();
      1: t = $urandom_range(0, 2000) - 1000;
      default: begin
        case ($urandom_range(0, 3))
          0: t = 32'sh7fff_ffff;
          1: t = 32'sh8000_0000;
          2: t = 32'sh0000_0000;
          default: t = 32'shffff_ffff;
        endcase
      end
    endcase
    return t;
  endfunction

  // small gains keep the drive off the clamp, large ones pin it there
  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 2))
      0: return 16'($urandom_range(0, 63));
      1: return 16'($urandom_range(0, 1023));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // count words that the core acts on; unused-command words come on top
  function automatic void queue_random(int count, int tick_pct);
    int made;
    int roll;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(0, 99);
      if (roll < tick_pct) begin
        queue_word(CMD_TICK, pick_speed(), pick_speed(), $urandom());
        made++;
      end else if (roll < tick_pct + (100 - tick_pct) / 2) begin
        queue_word(CMD_SET_TARGET, 16'($urandom()), 16'($urandom()), pick_target());
        made++;
      end else if (roll < 97) begin
        queue_word(CMD_CLEAR, 16'($urandom()), 16'($urandom()), $urandom());
        made++;
      end else begin
        queue_word(CMD_UNUSED, 16'($urandom()), 16'($urandom()), $urandom());
      end
    end
  endfunction

  // sender holds off until the core has drained, then lets the pipe settle
  task automatic wait_quiet();
    while (queued_words.size() != 0 || in_ch.valid || expected_updates.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_POSITION_MODE: sh_mode   = data[0];
      REG_GAIN_P:        sh_gain_p = data;
      REG_GAIN_I:        sh_gain_i = data;
      REG_GAIN_D:        sh_gain_d = data;
      REG_UPDATE_DIVIDE: sh_divide = data[7:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic mode, logic [15:0] kp, logic [15:0] ki,
                               logic [15:0] kd, logic [7:0] divide);
    write_reg(REG_POSITION_MODE, {15'd0, mode});
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_UPDATE_DIVIDE, {8'd0, divide});
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // driver: next word at the falling edge once the last one was taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!in_ch.valid || in_fired) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else if (queued_words.size() != 0) begin
        in_ch.payload <= queued_words.pop_front();
        in_ch.valid   <= 1'b1;
        send_gap = draw_wait();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: a fresh stall drawn after every drive word taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_fired) stall_left = draw_wait();
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: both handshakes sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_fired  = in_ch.valid && in_ch.ready;
    res_fired = res_ch.valid && res_ch.ready;
    if (!rst) begin
      // a drive word always stems from an older tick, so check first
      if (res_fired) check_update(res_ch.payload);
      if (in_fired) advance_controller(in_ch.payload);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    res_ch.ready  = 1'b0;
    calm          = 1'b0;
    failures      = 0;
    cycle_count   = 0;
    sh_mode       = 1'b0;
    sh_gain_p     = GAIN_P_RESET;
    sh_gain_i     = GAIN_I_RESET;
    sh_gain_d     = GAIN_D_RESET;
    sh_divide     = DIVIDE_RESET;
    tick_count    = '0;
    target_acc    = '0;
    actual_acc    = '0;
    err_now       = '0;
    err_prev      = '0;
    err_prev2     = '0;
    drive_acc     = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register defaults: seven ticks stay under the divider of ten
    queue_word(CMD_SET_TARGET, 16'sd0, 16'sd0, 32'sd500);
    repeat (7) queue_word(CMD_TICK, 16'sd100, 16'($urandom()), 32'sd0);
    wait_quiet();
    // lowering the divider below the count fires on the very next tick
    load_settings(sh_mode, sh_gain_p, sh_gain_i, sh_gain_d, 8'd3);
    queue_word(CMD_TICK, 16'sh8000, 16'sh7fff, 32'sd0);
    wait_quiet();

    // speed loop every tick: speed extremes, error saturation both ways,
    // clear, and an unused command with every bit set
    load_settings(1'b0, sh_gain_p, sh_gain_i, sh_gain_d, 8'd1);
    queue_word(CMD_TICK, 16'sh7fff, 16'sd0, 32'sd0);
    queue_word(CMD_SET_TARGET, 16'sd0, 16'sd0, 32'sh7fff_ffff);
    queue_word(CMD_TICK, 16'sh8000, 16'sd0, 32'sd0);
    queue_word(CMD_SET_TARGET, 16'sd0, 16'sd0, 32'sh8000_0000);
    queue_word(CMD_TICK, 16'sh7fff, 16'sd0, 32'sd0);
    queue_word(CMD_CLEAR, 16'sd0, 16'sd0, 32'sd0);
    queue_word(CMD_UNUSED, 16'shffff, 16'shffff, 32'shffff_ffff);
    queue_word(CMD_TICK, 16'sd0, 16'sd0, 32'sd0);
    wait_quiet();

    // position follow with a zero divider: target accumulator saturates
    load_settings(1'b1, sh_gain_p, sh_gain_i, sh_gain_d, 8'd0);
    queue_word(CMD_SET_TARGET, 16'sd0, 16'sd0, 32'sh7fff_fff0);
    queue_word(CMD_TICK, 16'sh7fff, 16'sh8000, 32'sd0);
    queue_word(CMD_CLEAR, 16'sd0, 16'sd0, 32'sd0);
    queue_word(CMD_TICK, 16'shffff, 16'shffff, 32'sd0);
    queue_word(CMD_TICK, 16'sd0, 16'sh7fff, 32'sd0);
    wait_quiet();

    // random phases; loop state carries over every reprogramming
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_settings(1'b0, 16'd0, 16'd0, 16'd0, 8'd1);
        1: load_settings(1'b1, 16'hffff, 16'hffff, 16'hffff, 8'd1);
        2: load_settings(1'b0, 16'hffff, 16'd0, 16'd0, 8'd0);
        3: load_settings(1'b1, 16'($urandom_range(0, 63)), 16'($urandom_range(0, 63)),
                         16'($urandom_range(0, 63)), 8'd2);
        default: load_settings(1'($urandom_range(0, 1)), pick_gain(), pick_gain(),
                               pick_gain(), 8'($urandom_range(0, 4)));
      endcase
      calm = (ph % 3 == 2);
      queue_random(15, 82);
      wait_quiet();
    end

    // slowest divider: nearly all ticks so at least one update comes out
    calm = 1'b0;
    load_settings(1'($urandom_range(0, 1)), pick_gain(), pick_gain(), pick_gain(), 8'd255);
    queue_random(265, 97);
    wait_quiet();

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
